// File: hw/rtl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

    localparam int ADC_BITS_DEF  = 10;
    localparam int TICK_BITS_DEF = 16;

    localparam int CELLS       = 4;
    localparam int CELL_IDX_W  = 2;
    localparam int CNT_W       = 3;
    localparam int MV_W        = 15;
    localparam int PCT_W       = 7;
    localparam int LED_W       = 4;
    localparam int PERIOD_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [MV_W-1:0] PACK_EMPTY_MV  = 15'd12000;
    localparam logic [MV_W-1:0] PACK_FULL_MV   = 15'd17000;
    localparam logic [MV_W-1:0] LOW_CELL_RESET = 15'd3200;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd8000;
    localparam int ON_RESET  = 6000;
    localparam int OFF_RESET = 2000;

    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY   = 7'd0;
    localparam logic [PCT_W-1:0] PCT_LVL_4   = 7'd82;
    localparam logic [PCT_W-1:0] PCT_LVL_3   = 7'd75;
    localparam logic [PCT_W-1:0] PCT_LVL_2   = 7'd50;
    localparam logic [PCT_W-1:0] PCT_LVL_1   = 7'd25;
    localparam logic [PCT_W-1:0] DUTY_BASE   = 7'd10;

    localparam logic [LED_W-1:0] LED_FOUR  = 4'hF;
    localparam logic [LED_W-1:0] LED_THREE = 4'h7;
    localparam logic [LED_W-1:0] LED_TWO   = 4'h3;
    localparam logic [LED_W-1:0] LED_ONE   = 4'h1;
    localparam logic [LED_W-1:0] LED_NONE  = 4'h0;
    localparam logic [LED_W-1:0] LED_OVER  = 4'h8;
    localparam logic [LED_W-1:0] LED_UNDER = 4'hC;

    // (pack - 12000) / 50, exact below 2^13
    localparam int BAND_W          = 13;
    localparam int BAND_PROD_W     = 27;
    localparam int PCT_SHIFT       = 19;
    localparam logic [13:0] PCT_RECIP = 14'd10486;

    // 4*pct / 5, exact below 2^9
    localparam int DUTY_PROD_W     = 19;
    localparam int DUTY_SHIFT      = 12;
    localparam logic [9:0] DUTY_RECIP = 10'd820;

    // period*duty / 100, exact below 2^23
    localparam int ON_PROD_W       = 23;
    localparam int ON_FULL_W       = 47;
    localparam int ON_SHIFT        = 30;
    localparam logic [23:0] ON_RECIP = 24'd10737419;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE,
        OP_CLASS,
        OP_PCT,
        OP_DUTY,
        OP_ON,
        OP_COMMIT,
        OP_TICK,
        OP_PUBLISH
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CLASS,
        ST_PCT,
        ST_DUTY,
        ST_ON,
        ST_COMMIT,
        ST_TICK,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        CLS_BAND,
        CLS_OVER,
        CLS_UNDER
    } cls_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOW_CELL   = 1'b0,
        CFG_PWM_PERIOD = 1'b1
    } cfg_sel_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpm_ctrl.sv
`default_nettype none

module bpm_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_mode,
    output logic               s_ready,
    input  wire bpm_pkg::sts_t sts,
    output bpm_pkg::cmd_t      cmd
);

    bpm_pkg::state_t              state_reg, state_next;
    logic [bpm_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpm_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd.op     = bpm_pkg::OP_NONE;
        cmd.cnt    = cnt_reg;
        unique case (state_reg)
            bpm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = bpm_pkg::OP_LOAD;
                    cnt_next   = '0;
                    state_next = s_mode ? bpm_pkg::ST_TICK : bpm_pkg::ST_SCALE;
                end
            end
            bpm_pkg::ST_SCALE: begin
                cmd.op = bpm_pkg::OP_SCALE;
                if (cnt_reg == bpm_pkg::CNT_W'(bpm_pkg::CELLS)) begin
                    state_next = bpm_pkg::ST_CLASS;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bpm_pkg::ST_CLASS: begin
                cmd.op     = bpm_pkg::OP_CLASS;
                state_next = bpm_pkg::ST_PCT;
            end
            bpm_pkg::ST_PCT: begin
                cmd.op     = bpm_pkg::OP_PCT;
                state_next = bpm_pkg::ST_DUTY;
            end
            bpm_pkg::ST_DUTY: begin
                cmd.op     = bpm_pkg::OP_DUTY;
                state_next = bpm_pkg::ST_ON;
            end
            bpm_pkg::ST_ON: begin
                cmd.op     = bpm_pkg::OP_ON;
                state_next = bpm_pkg::ST_COMMIT;
            end
            bpm_pkg::ST_COMMIT: begin
                cmd.op     = bpm_pkg::OP_COMMIT;
                state_next = bpm_pkg::ST_OUT;
            end
            bpm_pkg::ST_TICK: begin
                cmd.op     = bpm_pkg::OP_TICK;
                state_next = bpm_pkg::ST_OUT;
            end
            bpm_pkg::ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.op     = bpm_pkg::OP_PUBLISH;
                    state_next = bpm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/bpm_dp.sv
`default_nettype none

module bpm_dp #(
    parameter int ADC_BITS  = bpm_pkg::ADC_BITS_DEF,
    parameter int TICK_BITS = bpm_pkg::TICK_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire bpm_pkg::cmd_t                      cmd,
    output bpm_pkg::sts_t                           sts,
    input  wire logic                               s_mode,
    input  wire logic [ADC_BITS-1:0]                s_tap_one,
    input  wire logic [ADC_BITS-1:0]                s_tap_two,
    input  wire logic [ADC_BITS-1:0]                s_tap_three,
    input  wire logic [ADC_BITS-1:0]                s_tap_four,
    input  wire logic                               cfg_we,
    input  wire logic [bpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [bpm_pkg::CELLS-1:0]               m_low_cell_flags,
    output logic [bpm_pkg::LED_W-1:0]               m_led_bar,
    output logic [bpm_pkg::PCT_W-1:0]               m_charge_percent,
    output logic [bpm_pkg::MV_W-1:0]                m_pack_mv,
    output logic                                    m_pwm_out
);

    localparam int MV_W      = bpm_pkg::MV_W;
    localparam int PCT_W     = bpm_pkg::PCT_W;
    localparam int LED_W     = bpm_pkg::LED_W;
    localparam int CELLS     = bpm_pkg::CELLS;
    localparam int IDX_W     = bpm_pkg::CELL_IDX_W;
    localparam int CNT_W     = bpm_pkg::CNT_W;
    localparam int PERIOD_W  = bpm_pkg::PERIOD_W;

    // code*k*5000 / (2^ADC_BITS - 1) by reciprocal, exact below 2^PROD_W
    localparam int PROD_W    = ADC_BITS + MV_W;
    localparam int RECIP_W   = PROD_W + 1;
    localparam int MV_FULL_W = PROD_W + RECIP_W;
    localparam int MV_SHIFT  = PROD_W + ADC_BITS;
    localparam logic [63:0] MV_DIV        = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] MV_RECIP_FULL = ((64'd1 << MV_SHIFT) + MV_DIV - 64'd1) / MV_DIV;
    localparam logic [RECIP_W-1:0] MV_RECIP = MV_RECIP_FULL[RECIP_W-1:0];

    localparam logic [MV_W-1:0] SCALE_MV [CELLS] = '{15'd5000, 15'd10000, 15'd15000, 15'd20000};

    localparam int SAT_W = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W;
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
    localparam logic [TICK_BITS-1:0] TICK_ONE = TICK_BITS'(1);

    function automatic logic [TICK_BITS-1:0] sat_ticks(input logic [PERIOD_W-1:0] v);
        logic [SAT_W-1:0] ext;
        ext = SAT_W'(v);
        if (ext > SAT_W'(TICK_MAX)) begin
            return TICK_MAX;
        end
        return ext[TICK_BITS-1:0];
    endfunction

    logic                                      mode_reg;
    logic [ADC_BITS-1:0]                       tap_reg [CELLS];
    logic [PROD_W-1:0]                         prod_reg;
    logic [MV_W-1:0]                           mv_reg [CELLS];
    logic [CELLS-1:0]                          flags_reg;
    bpm_pkg::cls_t                             cls_reg;
    logic [bpm_pkg::BAND_PROD_W-1:0]           band_prod_reg;
    logic [PCT_W-1:0]                          pct_reg;
    logic [LED_W-1:0]                          leds_reg;
    logic [bpm_pkg::DUTY_PROD_W-1:0]           duty_prod_reg;
    logic [bpm_pkg::ON_PROD_W-1:0]             on_prod_reg;

    logic [MV_W-1:0]                           low_cell_reg;
    logic [PERIOD_W-1:0]                       period_reg;
    logic                                      pwm_level_reg;
    logic [TICK_BITS-1:0]                      ticks_left_reg;
    logic [TICK_BITS-1:0]                      on_count_reg;
    logic [TICK_BITS-1:0]                      off_count_reg;
    logic [LED_W-1:0]                          held_leds_reg;
    logic [PCT_W-1:0]                          held_pct_reg;
    logic                                      m_valid_reg;

    logic [CELLS-1:0]                          m_flags_reg;
    logic [LED_W-1:0]                          m_led_reg;
    logic [PCT_W-1:0]                          m_pct_reg;
    logic [MV_W-1:0]                           m_pack_reg;
    logic                                      m_pwm_reg;

    logic [IDX_W-1:0]                          scale_idx;
    logic [CNT_W-1:0]                          cnt_dec;
    logic [IDX_W-1:0]                          mv_idx;
    logic [PROD_W-1:0]                         prod_next;
    logic [MV_FULL_W-1:0]                      mv_full;
    logic [MV_W-1:0]                           mv_new;
    logic [MV_W-1:0]                           mv_prev [CELLS];
    logic [MV_W-1:0]                           cell_diff [CELLS];
    logic [CELLS-1:0]                          flags_calc;
    logic [MV_W-1:0]                           pack;
    logic [MV_W-1:0]                           band_off;
    logic [bpm_pkg::BAND_PROD_W-1:0]           band_prod;
    bpm_pkg::cls_t                             cls_calc;
    logic [PCT_W-1:0]                          pct_band;
    logic [PCT_W-1:0]                          pct_calc;
    logic [LED_W-1:0]                          leds_calc;
    logic [bpm_pkg::DUTY_PROD_W-1:0]           duty_prod;
    logic [PCT_W-1:0]                          duty;
    logic [bpm_pkg::ON_PROD_W-1:0]             on_prod;
    logic [bpm_pkg::ON_FULL_W-1:0]             on_full;
    logic [PERIOD_W-1:0]                       on_val;
    logic [PERIOD_W-1:0]                       off_val;

    assign scale_idx = cmd.cnt[IDX_W-1:0];
    assign cnt_dec   = cmd.cnt - 1'b1;
    assign mv_idx    = cnt_dec[IDX_W-1:0];
    assign prod_next = PROD_W'(tap_reg[scale_idx]) * PROD_W'(SCALE_MV[scale_idx]);
    assign mv_full   = MV_FULL_W'(prod_reg) * MV_FULL_W'(MV_RECIP);
    assign mv_new    = mv_full[MV_SHIFT +: MV_W];

    always_comb begin
        mv_prev[0] = '0;
        for (int k = 1; k < CELLS; k++) begin
            mv_prev[k] = mv_reg[k-1];
        end
        for (int k = 0; k < CELLS; k++) begin
            cell_diff[k]  = mv_reg[k] - mv_prev[k];
            flags_calc[k] = (mv_reg[k] >= mv_prev[k]) && (cell_diff[k] < low_cell_reg);
        end
    end

    assign pack      = mv_reg[CELLS-1];
    assign band_off  = pack - bpm_pkg::PACK_EMPTY_MV;
    assign band_prod = bpm_pkg::BAND_PROD_W'(band_off[bpm_pkg::BAND_W-1:0])
                     * bpm_pkg::BAND_PROD_W'(bpm_pkg::PCT_RECIP);

    always_comb begin
        priority if (pack > bpm_pkg::PACK_EMPTY_MV && pack < bpm_pkg::PACK_FULL_MV) begin
            cls_calc = bpm_pkg::CLS_BAND;
        end else if (pack > bpm_pkg::PACK_FULL_MV) begin
            cls_calc = bpm_pkg::CLS_OVER;
        end else begin
            cls_calc = bpm_pkg::CLS_UNDER;
        end
    end

    assign pct_band = band_prod_reg[bpm_pkg::PCT_SHIFT +: PCT_W];

    always_comb begin
        pct_calc  = bpm_pkg::PCT_FULL;
        leds_calc = bpm_pkg::LED_UNDER;
        unique case (cls_reg)
            bpm_pkg::CLS_BAND: begin
                pct_calc = pct_band;
                priority if (pct_band > bpm_pkg::PCT_LVL_4) begin
                    leds_calc = bpm_pkg::LED_FOUR;
                end else if (pct_band > bpm_pkg::PCT_LVL_3) begin
                    leds_calc = bpm_pkg::LED_THREE;
                end else if (pct_band > bpm_pkg::PCT_LVL_2) begin
                    leds_calc = bpm_pkg::LED_TWO;
                end else if (pct_band > bpm_pkg::PCT_LVL_1) begin
                    leds_calc = bpm_pkg::LED_ONE;
                end else begin
                    leds_calc = bpm_pkg::LED_NONE;
                end
            end
            bpm_pkg::CLS_OVER: begin
                pct_calc  = bpm_pkg::PCT_EMPTY;
                leds_calc = bpm_pkg::LED_OVER;
            end
            default: begin
                pct_calc  = bpm_pkg::PCT_FULL;
                leds_calc = bpm_pkg::LED_UNDER;
            end
        endcase
    end

    assign duty_prod = bpm_pkg::DUTY_PROD_W'({pct_reg, 2'b00})
                     * bpm_pkg::DUTY_PROD_W'(bpm_pkg::DUTY_RECIP);
    assign duty      = duty_prod_reg[bpm_pkg::DUTY_SHIFT +: PCT_W] + bpm_pkg::DUTY_BASE;
    assign on_prod   = bpm_pkg::ON_PROD_W'(period_reg) * bpm_pkg::ON_PROD_W'(duty);
    assign on_full   = bpm_pkg::ON_FULL_W'(on_prod_reg) * bpm_pkg::ON_FULL_W'(bpm_pkg::ON_RECIP);
    assign on_val    = on_full[bpm_pkg::ON_SHIFT +: PERIOD_W];
    assign off_val   = period_reg - on_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_cell_reg   <= bpm_pkg::LOW_CELL_RESET;
            period_reg     <= bpm_pkg::PERIOD_RESET;
            pwm_level_reg  <= 1'b0;
            ticks_left_reg <= TICK_BITS'(bpm_pkg::ON_RESET);
            on_count_reg   <= TICK_BITS'(bpm_pkg::ON_RESET);
            off_count_reg  <= TICK_BITS'(bpm_pkg::OFF_RESET);
            held_leds_reg  <= bpm_pkg::LED_NONE;
            held_pct_reg   <= bpm_pkg::PCT_EMPTY;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (bpm_pkg::cfg_sel_t'(cfg_index))
                    bpm_pkg::CFG_LOW_CELL:   low_cell_reg <= cfg_wdata[MV_W-1:0];
                    bpm_pkg::CFG_PWM_PERIOD: period_reg   <= cfg_wdata[PERIOD_W-1:0];
                endcase
            end
            if (cmd.op == bpm_pkg::OP_COMMIT) begin
                on_count_reg  <= sat_ticks(on_val);
                off_count_reg <= sat_ticks(off_val);
                held_leds_reg <= leds_reg;
                held_pct_reg  <= pct_reg;
            end
            if (cmd.op == bpm_pkg::OP_TICK) begin
                if (ticks_left_reg == TICK_ONE) begin
                    pwm_level_reg  <= !pwm_level_reg;
                    ticks_left_reg <= pwm_level_reg ? off_count_reg : on_count_reg;
                end else begin
                    ticks_left_reg <= ticks_left_reg - 1'b1;
                end
            end
            if (cmd.op == bpm_pkg::OP_PUBLISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            bpm_pkg::OP_LOAD: begin
                mode_reg   <= s_mode;
                tap_reg[0] <= s_tap_one;
                tap_reg[1] <= s_tap_two;
                tap_reg[2] <= s_tap_three;
                tap_reg[3] <= s_tap_four;
            end
            bpm_pkg::OP_SCALE: begin
                if (cmd.cnt != CNT_W'(CELLS)) begin
                    prod_reg <= prod_next;
                end
                if (cmd.cnt != '0) begin
                    mv_reg[mv_idx] <= mv_new;
                end
            end
            bpm_pkg::OP_CLASS: begin
                flags_reg     <= flags_calc;
                cls_reg       <= cls_calc;
                band_prod_reg <= band_prod;
            end
            bpm_pkg::OP_PCT: begin
                pct_reg  <= pct_calc;
                leds_reg <= leds_calc;
            end
            bpm_pkg::OP_DUTY: begin
                duty_prod_reg <= duty_prod;
            end
            bpm_pkg::OP_ON: begin
                on_prod_reg <= on_prod;
            end
            bpm_pkg::OP_PUBLISH: begin
                m_flags_reg <= mode_reg ? '0 : flags_reg;
                m_pack_reg  <= mode_reg ? '0 : pack;
                m_led_reg   <= held_leds_reg;
                m_pct_reg   <= held_pct_reg;
                m_pwm_reg   <= pwm_level_reg;
            end
            default: begin
            end
        endcase
    end

    assign sts.out_busy  = m_valid_reg && !m_ready;

    assign m_valid          = m_valid_reg;
    assign m_low_cell_flags = m_flags_reg;
    assign m_led_bar        = m_led_reg;
    assign m_charge_percent = m_pct_reg;
    assign m_pack_mv        = m_pack_reg;
    assign m_pwm_out        = m_pwm_reg;

endmodule

`default_nettype wire

// File: hw/rtl/battery_pack_monitor_pwm_unit.sv
// Four-cell pack monitor with PWM charge indicator. A word with s_mode low carries
// four ADC taps; the block scales each to millivolts, flags cells below low_cell_mv,
// and derives pack voltage, charge percent, LED bar and the PWM on/off counts, which
// take effect at the next reload. A word with s_mode high is one timer tick of the
// PWM. Every input word gives exactly one result word. A measurement passes through the
// shared tap-scaling multiplier (one tap per cycle) and then the chain of five
// registered steps for class, percent, duty, on count and commit. The next word is
// accepted in the cycle after the result is loaded into the output register, even
// while that result is still waiting for m_ready. Configuration is written through
// cfg_we / cfg_index / cfg_wdata with index 0 low_cell_mv, index 1 pwm_period_ticks.
`default_nettype none

module battery_pack_monitor_pwm_unit #(
    parameter int ADC_BITS  = bpm_pkg::ADC_BITS_DEF,
    parameter int TICK_BITS = bpm_pkg::TICK_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_mode,
    input  wire logic [ADC_BITS-1:0]                s_tap_one,
    input  wire logic [ADC_BITS-1:0]                s_tap_two,
    input  wire logic [ADC_BITS-1:0]                s_tap_three,
    input  wire logic [ADC_BITS-1:0]                s_tap_four,
    input  wire logic                               cfg_we,
    input  wire logic [bpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [bpm_pkg::CELLS-1:0]               m_low_cell_flags,
    output logic [bpm_pkg::LED_W-1:0]               m_led_bar,
    output logic [bpm_pkg::PCT_W-1:0]               m_charge_percent,
    output logic [bpm_pkg::MV_W-1:0]                m_pack_mv,
    output logic                                    m_pwm_out
);

    bpm_pkg::cmd_t cmd;
    bpm_pkg::sts_t sts;

    bpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bpm_dp #(
        .ADC_BITS  (ADC_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_mode           (s_mode),
        .s_tap_one        (s_tap_one),
        .s_tap_two        (s_tap_two),
        .s_tap_three      (s_tap_three),
        .s_tap_four       (s_tap_four),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_low_cell_flags (m_low_cell_flags),
        .m_led_bar        (m_led_bar),
        .m_charge_percent (m_charge_percent),
        .m_pack_mv        (m_pack_mv),
        .m_pwm_out        (m_pwm_out)
    );

    a_one_word_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in flight");

    a_publish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == bpm_pkg::OP_PUBLISH |-> !sts.out_busy)
        else $error("result register overwritten before it was taken");

    a_percent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_charge_percent <= bpm_pkg::PCT_FULL)
        else $error("charge percent above full scale");

    a_over_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_led_bar == bpm_pkg::LED_OVER |-> m_charge_percent == bpm_pkg::PCT_EMPTY)
        else $error("over-voltage LED pattern with nonzero percent");

endmodule

`default_nettype wire

// File: bench/battery_pack_monitor_pwm_unit_checker.sv
`timescale 1ns / 1ps

module battery_pack_monitor_pwm_unit_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic [bpm_pkg::ADC_BITS_DEF-1:0]      s_tap_one,
    input  logic [bpm_pkg::ADC_BITS_DEF-1:0]      s_tap_two,
    input  logic [bpm_pkg::ADC_BITS_DEF-1:0]      s_tap_three,
    input  logic [bpm_pkg::ADC_BITS_DEF-1:0]      s_tap_four,
    input  logic                                  cfg_we,
    input  bpm_pkg::cfg_sel_t                     cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [bpm_pkg::CELLS-1:0]             m_low_cell_flags,
    input  logic [bpm_pkg::LED_W-1:0]             m_led_bar,
    input  logic [bpm_pkg::PCT_W-1:0]             m_charge_percent,
    input  logic [bpm_pkg::MV_W-1:0]              m_pack_mv,
    input  logic                                  m_pwm_out,
    output int                                    pending_words,
    output int                                    mismatch_count
);

    import bpm_pkg::*;

    typedef struct packed {
        logic [CELLS-1:0] flags;
        logic [LED_W-1:0] leds;
        logic [PCT_W-1:0] percent;
        logic [MV_W-1:0]  pack_mv;
        logic             pin;
    } status_t;

    logic [MV_W-1:0]     low_cell_mv_r;
    logic [PERIOD_W-1:0] period_r;
    logic                pin_r;
    logic [15:0]         ticks_left_r;
    logic [15:0]         on_ticks_r;
    logic [15:0]         off_ticks_r;
    logic [LED_W-1:0]    held_leds_r;
    logic [PCT_W-1:0]    held_pct_r;
    status_t             awaited_status [$];
    int                  errors;

    function automatic status_t monitor_step(input logic mode,
                                             input logic [ADC_BITS_DEF-1:0] t1,
                                             input logic [ADC_BITS_DEF-1:0] t2,
                                             input logic [ADC_BITS_DEF-1:0] t3,
                                             input logic [ADC_BITS_DEF-1:0] t4);
        int unsigned mv [0:4];
        int unsigned pct;
        int unsigned on_v;
        status_t w;
        w = '0;
        if (mode == 1'b0) begin
            mv[0] = 0;
            mv[1] = (32'(t1) * 5000) / 1023;
            mv[2] = (32'(t2) * 10000) / 1023;
            mv[3] = (32'(t3) * 15000) / 1023;
            mv[4] = (32'(t4) * 20000) / 1023;
            // a cell below the one beneath it wraps and never flags
            for (int k = 1; k <= 4; k++) begin
                if (mv[k] >= mv[k-1] && (mv[k] - mv[k-1]) < low_cell_mv_r)
                    w.flags[k-1] = 1'b1;
            end
            w.pack_mv = mv[4][MV_W-1:0];
            if (mv[4] > 12000 && mv[4] < 17000) begin
                pct = ((mv[4] - 12000) * 100) / 5000;
                if (pct > 82)
                    held_leds_r = 4'hF;
                else if (pct > 75)
                    held_leds_r = 4'h7;
                else if (pct > 50)
                    held_leds_r = 4'h3;
                else if (pct > 25)
                    held_leds_r = 4'h1;
                else
                    held_leds_r = 4'h0;
            end else if (mv[4] > 17000) begin
                pct = 0;
                held_leds_r = 4'h8;
            end else begin
                pct = 100;
                held_leds_r = 4'hC;
            end
            held_pct_r = pct[PCT_W-1:0];
            // new counts wait for the next reload
            on_v = (32'(period_r) * ((pct * 80) / 100 + 10)) / 100;
            on_ticks_r = (on_v > 32'hFFFF) ? 16'hFFFF : 16'(on_v);
            off_ticks_r = ((32'(period_r) - on_v) > 32'hFFFF) ? 16'hFFFF
                                                              : 16'(32'(period_r) - on_v);
        end else begin
            if (ticks_left_r == 16'd1) begin
                if (pin_r) begin
                    pin_r = 1'b0;
                    ticks_left_r = off_ticks_r;
                end else begin
                    pin_r = 1'b1;
                    ticks_left_r = on_ticks_r;
                end
            end else begin
                ticks_left_r = ticks_left_r - 16'd1;
            end
        end
        w.leds    = held_leds_r;
        w.percent = held_pct_r;
        w.pin     = pin_r;
        return w;
    endfunction

    function automatic int field_differs(input string field, input int unsigned want,
                                         input int unsigned got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        status_t seen;
        status_t due;
        if (!aresetn) begin
            low_cell_mv_r = LOW_CELL_RESET;
            period_r      = PERIOD_RESET;
            pin_r         = 1'b0;
            ticks_left_r  = 16'd6000;
            on_ticks_r    = 16'd6000;
            off_ticks_r   = 16'd2000;
            held_leds_r   = '0;
            held_pct_r    = '0;
            awaited_status.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOW_CELL: begin
                        low_cell_mv_r = cfg_wdata[MV_W-1:0];
                    end
                    CFG_PWM_PERIOD: begin
                        period_r = cfg_wdata[PERIOD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready)
                awaited_status.push_back(monitor_step(s_mode, s_tap_one, s_tap_two,
                                                      s_tap_three, s_tap_four));
            if (m_valid && m_ready) begin
                seen.flags   = m_low_cell_flags;
                seen.leds    = m_led_bar;
                seen.percent = m_charge_percent;
                seen.pack_mv = m_pack_mv;
                seen.pin     = m_pwm_out;
                if (awaited_status.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, seen);
                    errors++;
                end else begin
                    due = awaited_status.pop_front();
                    errors += field_differs("low_cell_flags", due.flags, seen.flags);
                    errors += field_differs("led_bar", due.leds, seen.leds);
                    errors += field_differs("charge_percent", due.percent, seen.percent);
                    errors += field_differs("pack_mv", due.pack_mv, seen.pack_mv);
                    errors += field_differs("pwm_out", due.pin, seen.pin);
                end
            end
        end
        pending_words  <= awaited_status.size();
        mismatch_count <= errors;
    end

endmodule

// File: bench/battery_pack_monitor_pwm_unit_tb.sv
`timescale 1ns / 1ps

module battery_pack_monitor_pwm_unit_tb;

    import bpm_pkg::*;

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;
    localparam int   PHASES       = 8;
    localparam int   PHASE_WORDS  = 170;
    localparam int   CYCLE_LIMIT  = 2000000;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic                        s_mode      = 1'b0;
    logic [ADC_BITS_DEF-1:0]     s_tap_one   = '0;
    logic [ADC_BITS_DEF-1:0]     s_tap_two   = '0;
    logic [ADC_BITS_DEF-1:0]     s_tap_three = '0;
    logic [ADC_BITS_DEF-1:0]     s_tap_four  = '0;
    logic                        cfg_we      = 1'b0;
    cfg_sel_t                    cfg_index   = CFG_LOW_CELL;
    logic [CFG_DATA_W-1:0]       cfg_wdata   = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [CELLS-1:0]            m_low_cell_flags;
    logic [LED_W-1:0]            m_led_bar;
    logic [PCT_W-1:0]            m_charge_percent;
    logic [MV_W-1:0]             m_pack_mv;
    logic                        m_pwm_out;

    int   pending_words;
    int   mismatch_count;
    logic gaps_on   = 1'b0;
    logic stalls_on = 1'b0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   measure_words = 0;
    int   tick_words = 0;
    int   settings_written = 0;
    int   sweep_codes [12] = '{613, 614, 679, 680, 742, 743, 808, 809, 826, 827, 869, 870};

    battery_pack_monitor_pwm_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_tap_one        (s_tap_one),
        .s_tap_two        (s_tap_two),
        .s_tap_three      (s_tap_three),
        .s_tap_four       (s_tap_four),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_low_cell_flags (m_low_cell_flags),
        .m_led_bar        (m_led_bar),
        .m_charge_percent (m_charge_percent),
        .m_pack_mv        (m_pack_mv),
        .m_pwm_out        (m_pwm_out)
    );

    battery_pack_monitor_pwm_unit_checker status_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_tap_one        (s_tap_one),
        .s_tap_two        (s_tap_two),
        .s_tap_three      (s_tap_three),
        .s_tap_four       (s_tap_four),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_low_cell_flags (m_low_cell_flags),
        .m_led_bar        (m_led_bar),
        .m_charge_percent (m_charge_percent),
        .m_pack_mv        (m_pack_mv),
        .m_pwm_out        (m_pwm_out),
        .pending_words    (pending_words),
        .mismatch_count   (mismatch_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results outstanding", $time, pending_words);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure in bursts of random length
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic mode, input logic [ADC_BITS_DEF-1:0] t1,
                             input logic [ADC_BITS_DEF-1:0] t2,
                             input logic [ADC_BITS_DEF-1:0] t3,
                             input logic [ADC_BITS_DEF-1:0] t4);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_tap_one   <= t1;
        s_tap_two   <= t2;
        s_tap_three <= t3;
        s_tap_four  <= t4;
        do @(posedge aclk); while (!s_ready);
        if (mode == MODE_TICK)
            tick_words++;
        else
            measure_words++;
    endtask

    task automatic send_tick();
        send_word(MODE_TICK, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
    endtask

    task automatic set_thresholds(input logic [CFG_DATA_W-1:0] low_cell,
                                  input logic [CFG_DATA_W-1:0] period);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_CELL;
        cfg_wdata <= low_cell;
        @(posedge aclk);
        cfg_index <= CFG_PWM_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    initial begin
        int                      phase;
        int                      n;
        int                      j;
        int                      roll;
        int unsigned             low_cell;
        int unsigned             period;
        int unsigned             total;
        int unsigned             code;
        bit                      with_ticks;
        logic [ADC_BITS_DEF-1:0] tap [1:4];

        repeat (10) @(posedge aclk);
        aresetn   <= 1'b1;
        gaps_on   <= 1'b1;
        stalls_on <= 1'b1;

        // rails, inverted stacks, and pack codes around every band edge
        send_word(MODE_MEASURE, 10'd0, 10'd0, 10'd0, 10'd0);
        send_word(MODE_MEASURE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_word(MODE_MEASURE, 10'd1023, 10'd0, 10'd1023, 10'd0);
        foreach (sweep_codes[i])
            send_word(MODE_MEASURE, 10'(sweep_codes[i]), 10'(sweep_codes[i]),
                      10'(sweep_codes[i]), 10'(sweep_codes[i]));

        // shorten the PWM counts
        set_thresholds(16'd3200, 16'd100);
        send_word(MODE_MEASURE, 10'd700, 10'd700, 10'd700, 10'd700);

        set_thresholds(16'd0, 16'd100);
        send_word(MODE_MEASURE, 10'd0, 10'd0, 10'd0, 10'd0);
        set_thresholds(16'd20000, 16'd100);
        send_word(MODE_MEASURE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        set_thresholds(16'hFFFF, 16'd100);
        send_word(MODE_MEASURE, 10'd300, 10'd500, 10'd900, 10'd800);

        for (phase = 0; phase < PHASES; phase++) begin
            with_ticks = 1'b1;
            low_cell = $urandom_range(0, 20000);
            period = $urandom_range(100, 400);
            case (phase)
                0: begin
                    low_cell = 3200;
                    period = 100;
                end
                1: begin
                    low_cell = 0;
                end
                2: begin
                    low_cell = 20000;
                end
                3: begin
                    period = 65535;
                    with_ticks = 1'b0;
                end
                5: begin
                    period = $urandom_range(401, 65534);
                    with_ticks = 1'b0;
                end
                6: begin
                    low_cell = $urandom_range(2500, 4300);
                    period = 100;
                end
                default: begin
                end
            endcase
            set_thresholds(16'(low_cell), 16'(period));
            gaps_on   <= (phase % 3 != 2);
            stalls_on <= (phase % 3 != 2);
            for (n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                if (with_ticks && n != 0 && roll < 45) begin
                    send_tick();
                end else begin
                    if (roll % 5 == 0) begin
                        for (j = 1; j <= 4; j++)
                            tap[j] = $urandom_range(0, 1023);
                    end else begin
                        // plausible stack, now and then a weak or reversed cell
                        total = 0;
                        for (j = 1; j <= 4; j++) begin
                            if ($urandom_range(0, 5) == 0)
                                total += $urandom_range(0, 3600);
                            else
                                total += $urandom_range(2600, 4300);
                            code = (total * 1023) / (j * 5000);
                            tap[j] = (code > 1023) ? 10'd1023 : 10'(code);
                        end
                        if ($urandom_range(0, 9) == 0) begin
                            j = $urandom_range(2, 4);
                            tap[j] = $urandom_range(0, tap[j] / 4);
                        end
                    end
                    send_word(MODE_MEASURE, tap[1], tap[2], tap[3], tap[4]);
                end
            end
        end

        // zero period: both counts go to zero, back to back ticks
        set_thresholds(16'd3200, 16'd0);
        gaps_on   <= 1'b0;
        stalls_on <= 1'b0;
        send_word(MODE_MEASURE, 10'd0, 10'd0, 10'd0, 10'd0);
        repeat (170) send_tick();

        drain_results();
        repeat (20) @(posedge aclk);
        $display("Covered %0d measurement and %0d tick words over %0d register settings,",
                 measure_words, tick_words, settings_written);
        $display("including band edges, reversed cells, register extremes and timer countdown.");
        if (mismatch_count == 0 && pending_words == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_ctrl.sv
hw/rtl/bpm_dp.sv
hw/rtl/battery_pack_monitor_pwm_unit.sv
bench/battery_pack_monitor_pwm_unit_checker.sv
bench/battery_pack_monitor_pwm_unit_tb.sv
